// ----- rtl/gait_phase_classifier_core_assert.svh -----
// assertion macros for the gait phase classifier checker
`ifndef GAIT_PHASE_CLASSIFIER_CORE_ASSERT_SVH
`define GAIT_PHASE_CLASSIFIER_CORE_ASSERT_SVH

// consequent holds in the same cycle
`define GPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the following cycle
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gpc_pkg.sv -----
// shared types, constants and command tables of the gait phase classifier
package gpc_pkg;

    localparam int PRESSURE_W    = 10;
    localparam int ANGLE_W       = 16;
    localparam int MS_W          = 16;
    localparam int ALPHA_W       = 17;
    localparam int ALPHA_FRAC    = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 17;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 40;
    localparam int KNEE_W        = 7;
    localparam int STEPS_W       = 10;
    localparam int SPEED_W       = 10;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    localparam logic [PRESSURE_W-1:0] ZERO_RESET     = 10'd120;
    localparam logic [PRESSURE_W-1:0] SPAN_RESET     = 10'd700;
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 17'd9830;
    localparam logic [PRESSURE_W-1:0] LOADED_RESET   = 10'd245;
    localparam logic [PRESSURE_W-1:0] PRESWING_RESET = 10'd70;
    localparam logic [PRESSURE_W-1:0] UNLOAD_RESET   = 10'd140;
    localparam logic [PRESSURE_W-1:0] STOP_RESET     = 10'd1000;

    localparam logic signed [ANGLE_W-1:0] ANGLE_STANCE_LOW  = -16'sd400;
    localparam logic signed [ANGLE_W-1:0] ANGLE_STANCE_HIGH = 16'sd400;
    localparam logic signed [ANGLE_W-1:0] ANGLE_SWING_MID   = 16'sd500;

    localparam logic [MS_W-1:0] MS_MIN = 16'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESSURE_ZERO  = 3'd0,
        REG_PRESSURE_SPAN  = 3'd1,
        REG_LOAD_ALPHA     = 3'd2,
        REG_LOADED_LEVEL   = 3'd3,
        REG_PRESWING_LEVEL = 3'd4,
        REG_UNLOAD_LEVEL   = 3'd5,
        REG_STOP_LEVEL     = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_LOADING        = 3'd0,
        PH_MID_STANCE     = 3'd1,
        PH_TERM_STANCE    = 3'd2,
        PH_PRE_SWING      = 3'd3,
        PH_INITIAL_SWING  = 3'd4,
        PH_MID_SWING      = 3'd5,
        PH_TERM_SWING     = 3'd6,
        PH_UNKNOWN        = 3'd7
    } phase_t;

    function automatic logic [KNEE_W-1:0] knee_of(input phase_t ph);
        logic [KNEE_W-1:0] k;
        case (ph)
            PH_LOADING:       k = 7'd10;
            PH_MID_STANCE:    k = 7'd5;
            PH_TERM_STANCE:   k = 7'd0;
            PH_PRE_SWING:     k = 7'd20;
            PH_INITIAL_SWING: k = 7'd40;
            PH_MID_SWING:     k = 7'd60;
            PH_TERM_SWING:    k = 7'd15;
            default:          k = 7'd0;
        endcase
        return k;
    endfunction

    function automatic logic [STEPS_W-1:0] steps_of(input phase_t ph);
        logic [STEPS_W-1:0] s;
        case (ph)
            PH_LOADING:       s = 10'd100;
            PH_MID_STANCE:    s = 10'd50;
            PH_TERM_STANCE:   s = 10'd0;
            PH_PRE_SWING:     s = 10'd200;
            PH_INITIAL_SWING: s = 10'd400;
            PH_MID_SWING:     s = 10'd600;
            PH_TERM_SWING:    s = 10'd150;
            default:          s = 10'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_of(input phase_t ph);
        logic [SPEED_W-1:0] v;
        case (ph)
            PH_LOADING:       v = 10'd250;
            PH_MID_STANCE:    v = 10'd180;
            PH_TERM_STANCE:   v = 10'd220;
            PH_PRE_SWING:     v = 10'd350;
            PH_INITIAL_SWING: v = 10'd500;
            PH_MID_SWING:     v = 10'd550;
            PH_TERM_SWING:    v = 10'd300;
            default:          v = 10'd120;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/gait_phase_classifier_core.sv -----
// Gait phase classifier: one sample in, one phase and motor command out, one
// transfer per clock. A sample is captured in an input register; from there
// the load filter update (one 27x18 multiply at the default fraction width),
// the threshold and velocity compares and the command table lookup are worked
// out and written to the result register once the output side can advance.
// Stalls on the output side hold both registers. A raw pressure above the stop
// level latches an emergency stop until reset; from then on every result is
// zero with the stop flag set in tuser and the filter state stays frozen.
// Configuration writes are always accepted and must only be made while idle.
module gait_phase_classifier_core #(
    parameter int FRACTION_BITS = gpc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pressure_raw[9:0], shank_angle[25:10], elapsed_ms[41:26], zero fill
    input  logic [gpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // phase[2:0], knee_angle[9:3], target_steps[19:10], speed_sps[29:20],
    // filtered_load[39:30]
    output logic [gpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // emergency_stop[0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gpc_pkg::*;

    localparam int ACC_W = PRESSURE_W + FRACTION_BITS;
    localparam int D_W   = ACC_W + 1;
    localparam int P_W   = D_W + ALPHA_W + 1;
    localparam int VEL_W = 22;

    // configuration
    logic [PRESSURE_W-1:0] zero_reg, span_reg, loaded_reg, preswing_reg;
    logic [PRESSURE_W-1:0] unload_reg, stop_reg;
    logic [ALPHA_W-1:0]    alpha_reg;

    // state
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic signed [ANGLE_W-1:0] prev_angle_reg, prev_angle_next;
    logic                      latch_reg, latch_next;

    // input register
    logic                      in_valid_reg;
    logic [PRESSURE_W-1:0]     raw_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [MS_W-1:0]           ms_reg;

    // result register
    logic                      out_valid_reg;
    logic [OUT_TDATA_W-1:0]    out_data_reg, out_data_next;
    logic                      out_stop_reg, out_stop_next;

    logic advance, work;

    logic [ALPHA_W-1:0]          alpha_wr;
    logic signed [PRESSURE_W:0]  x_off;
    logic [PRESSURE_W-1:0]       x_clamp;
    logic signed [D_W-1:0]       d;
    logic signed [P_W-1:0]       d_ext, alpha_ext, prod, f_step, f_sum;
    logic [ACC_W-1:0]            f_new;
    logic                        loaded, preswing, unloading;
    logic signed [ANGLE_W:0]     a_diff;
    logic signed [VEL_W-1:0]     a_ext, a10, ms8, ms3;
    logic                        fwd, bwd, slow, stop_now;
    phase_t                      ph;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign work          = in_valid_reg && advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_stop_reg;

    assign alpha_wr = (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg     <= ZERO_RESET;
            span_reg     <= SPAN_RESET;
            alpha_reg    <= ALPHA_RESET;
            loaded_reg   <= LOADED_RESET;
            preswing_reg <= PRESWING_RESET;
            unload_reg   <= UNLOAD_RESET;
            stop_reg     <= STOP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRESSURE_ZERO:  zero_reg     <= cfg_data[PRESSURE_W-1:0];
                REG_PRESSURE_SPAN:  span_reg     <= cfg_data[PRESSURE_W-1:0];
                REG_LOAD_ALPHA:     alpha_reg    <= alpha_wr;
                REG_LOADED_LEVEL:   loaded_reg   <= cfg_data[PRESSURE_W-1:0];
                REG_PRESWING_LEVEL: preswing_reg <= cfg_data[PRESSURE_W-1:0];
                REG_UNLOAD_LEVEL:   unload_reg   <= cfg_data[PRESSURE_W-1:0];
                REG_STOP_LEVEL:     stop_reg     <= cfg_data[PRESSURE_W-1:0];
                default:            ;
            endcase
        end
    end

    // load filter
    always_comb
    begin
        x_off = $signed({1'b0, raw_reg}) - $signed({1'b0, zero_reg});
        if (x_off < 0)
            x_clamp = '0;
        else if (x_off[PRESSURE_W-1:0] > span_reg)
            x_clamp = span_reg;
        else
            x_clamp = x_off[PRESSURE_W-1:0];
        d         = $signed({1'b0, x_clamp, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, acc_reg});
        d_ext     = {{(P_W-D_W){d[D_W-1]}}, d};
        alpha_ext = $signed({{(P_W-ALPHA_W){1'b0}}, alpha_reg});
        prod      = d_ext * alpha_ext;
        f_step    = prod >>> ALPHA_FRAC;
        f_sum     = $signed({{(P_W-ACC_W){1'b0}}, acc_reg}) + f_step;
        f_new     = (f_sum < 0) ? '0 : f_sum[ACC_W-1:0];
        loaded    = f_new > {loaded_reg, {FRACTION_BITS{1'b0}}};
        preswing  = f_new > {preswing_reg, {FRACTION_BITS{1'b0}}};
        unloading = f_new < {unload_reg, {FRACTION_BITS{1'b0}}};
    end

    // shank velocity by cross-multiplication
    always_comb
    begin
        a_diff = {angle_reg[ANGLE_W-1], angle_reg} - {prev_angle_reg[ANGLE_W-1], prev_angle_reg};
        a_ext  = {{(VEL_W-ANGLE_W-1){a_diff[ANGLE_W]}}, a_diff};
        a10    = (a_ext <<< 3) + (a_ext <<< 1);
        ms8    = $signed({3'b000, ms_reg, 3'b000});
        ms3    = $signed({5'b00000, ms_reg, 1'b0}) + $signed({6'b000000, ms_reg});
        if (ms_reg < MS_MIN)
        begin
            fwd  = 1'b0;
            bwd  = 1'b0;
            slow = 1'b1;
        end
        else
        begin
            fwd  = a10 > ms8;
            bwd  = a10 < -ms8;
            slow = a10 <= ms3;
        end
    end

    // phase decision and result
    always_comb
    begin
        if (loaded)
        begin
            if (angle_reg < ANGLE_STANCE_LOW)
                ph = PH_LOADING;
            else if (angle_reg < ANGLE_STANCE_HIGH)
                ph = PH_MID_STANCE;
            else
                ph = PH_TERM_STANCE;
        end
        else if (preswing)
            ph = PH_PRE_SWING;
        else if (unloading && fwd && (angle_reg < ANGLE_SWING_MID))
            ph = PH_INITIAL_SWING;
        else if (unloading && fwd)
            ph = PH_MID_SWING;
        else if (unloading && (bwd || slow))
            ph = PH_TERM_SWING;
        else
            ph = PH_UNKNOWN;

        stop_now        = latch_reg || (raw_reg > stop_reg);
        acc_next        = acc_reg;
        prev_angle_next = prev_angle_reg;
        latch_next      = latch_reg;
        out_data_next   = out_data_reg;
        out_stop_next   = out_stop_reg;
        if (work)
        begin
            if (stop_now)
            begin
                latch_next    = 1'b1;
                out_data_next = '0;
                out_stop_next = 1'b1;
            end
            else
            begin
                acc_next        = f_new;
                prev_angle_next = angle_reg;
                out_data_next   = {f_new[ACC_W-1:FRACTION_BITS], speed_of(ph),
                                   steps_of(ph), knee_of(ph), ph};
                out_stop_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            prev_angle_reg <= '0;
            latch_reg      <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            prev_angle_reg <= prev_angle_next;
            latch_reg      <= latch_next;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            raw_reg   <= s_axis_tdata[PRESSURE_W-1:0];
            angle_reg <= s_axis_tdata[PRESSURE_W+ANGLE_W-1:PRESSURE_W];
            ms_reg    <= s_axis_tdata[PRESSURE_W+ANGLE_W+MS_W-1:PRESSURE_W+ANGLE_W];
        end
        out_data_reg <= out_data_next;
        out_stop_reg <= out_stop_next;
    end

endmodule

// ----- rtl/gpc_checker.sv -----
// port-level checker for the gait phase classifier, bound to the top level
`include "gait_phase_classifier_core_assert.svh"

module gpc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [gpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import gpc_pkg::*;

    logic [STEPS_W-1:0] knee_x10;

    assign knee_x10 = {3'b000, m_axis_tdata[9:3]} * 10'd10;

    // stalled result holds
    `GPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // stop results carry no command
    `GPC_ASSERT_NOW(a_stop_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "stop result not zeroed")

    // step target follows knee angle
    `GPC_ASSERT_NOW(a_steps_knee, clk, rst_n, m_axis_tvalid, m_axis_tdata[19:10] == knee_x10, "step target does not match knee angle")

    // terminal stance and unknown command a straight knee
    `GPC_ASSERT_NOW(a_straight_knee, clk, rst_n, m_axis_tvalid && ((m_axis_tdata[2:0] == PH_TERM_STANCE) || (m_axis_tdata[2:0] == PH_UNKNOWN)), m_axis_tdata[9:3] == '0, "straight-knee phase with nonzero knee angle")

endmodule

bind gait_phase_classifier_core gpc_checker u_gpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// self-checking stream testbench for the gait phase classifier core
module testbench;
    import gpc_pkg::*;

    localparam int FRAC        = FRACTION_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PERCENT = 36;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_SETUPS  = 8;
    localparam int PAD_W       = IN_TDATA_W - PRESSURE_W - ANGLE_W - MS_W;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic                  emergency_stop;
        logic [PRESSURE_W-1:0] filtered_load;
        logic [SPEED_W-1:0]    speed_sps;
        logic [STEPS_W-1:0]    target_steps;
        logic [KNEE_W-1:0]     knee_angle;
        phase_t                phase;
    } gait_cmd_t;

    typedef struct {
        logic [PRESSURE_W-1:0]     raw;
        logic signed [ANGLE_W-1:0] angle;
        logic [MS_W-1:0]           ms;
        bit                        typed;
        gait_cmd_t                 cmd;
    } sample_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the registers and the filter, angle and stop state
    logic [PRESSURE_W-1:0]     zero_cnt    = ZERO_RESET;
    logic [PRESSURE_W-1:0]     span_cnt    = SPAN_RESET;
    logic [ALPHA_W-1:0]        alpha_q16   = ALPHA_RESET;
    logic [PRESSURE_W-1:0]     loaded_lv   = LOADED_RESET;
    logic [PRESSURE_W-1:0]     preswing_lv = PRESWING_RESET;
    logic [PRESSURE_W-1:0]     unload_lv   = UNLOAD_RESET;
    logic [PRESSURE_W-1:0]     stop_lv     = STOP_RESET;
    longint                    load_acc    = 0;
    logic signed [ANGLE_W-1:0] last_angle  = '0;
    bit                        stop_latched = 1'b0;

    logic [KNEE_W-1:0]  knee_deg [8]  = '{7'd10, 7'd5, 7'd0, 7'd20, 7'd40, 7'd60, 7'd15, 7'd0};
    logic [SPEED_W-1:0] speed_tab [8] = '{10'd250, 10'd180, 10'd220, 10'd350,
                                          10'd500, 10'd550, 10'd300, 10'd120};

    gait_cmd_t   pending_cmds [$];
    sample_row_t directed_rows [$];

    int fault_count  = 0;
    int samples_sent = 0;
    int cmds_checked = 0;
    int setups_done  = 0;
    int cycle_count  = 0;
    bit no_gaps      = 1'b0;
    int raw_cap      = 1023;
    int walk_angle   = 0;
    bit walk_stance  = 1'b0;
    int walk_left    = 0;

    gait_phase_classifier_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_PRESSURE_ZERO:  zero_cnt = value[PRESSURE_W-1:0];
            REG_PRESSURE_SPAN:  span_cnt = value[PRESSURE_W-1:0];
            REG_LOAD_ALPHA:     alpha_q16 = (value > ALPHA_ONE) ? ALPHA_ONE : value;
            REG_LOADED_LEVEL:   loaded_lv = value[PRESSURE_W-1:0];
            REG_PRESWING_LEVEL: preswing_lv = value[PRESSURE_W-1:0];
            REG_UNLOAD_LEVEL:   unload_lv = value[PRESSURE_W-1:0];
            REG_STOP_LEVEL:     stop_lv = value[PRESSURE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic gait_cmd_t classify_sample(input logic [PRESSURE_W-1:0] raw,
                                                  input logic signed [ANGLE_W-1:0] angle,
                                                  input logic [MS_W-1:0] ms);
        gait_cmd_t cmd;
        longint    x;
        longint    f;
        longint    a10;
        longint    m;
        bit        loaded;
        bit        preswing;
        bit        unloading;
        bit        fwd;
        bit        bwd;
        bit        slow;
        phase_t    ph;
        cmd = '0;
        if (stop_latched || raw > stop_lv)
        begin
            stop_latched = 1'b1;
            cmd.emergency_stop = 1'b1;
            return cmd;
        end
        x = longint'(raw) - longint'(zero_cnt);
        if (x < 0)
            x = 0;
        if (x > longint'(span_cnt))
            x = longint'(span_cnt);
        // floor of alpha * error / 2^16
        f = load_acc + ((((x << FRAC) - load_acc) * longint'(alpha_q16)) >>> ALPHA_FRAC);
        if (f < 0)
            f = 0;
        load_acc = f;
        loaded    = f > (longint'(loaded_lv) << FRAC);
        preswing  = f > (longint'(preswing_lv) << FRAC);
        unloading = f < (longint'(unload_lv) << FRAC);
        // velocity compared as 10*da against k*dt, no division
        m   = longint'(ms);
        a10 = (longint'(angle) - longint'(last_angle)) * 10;
        if (ms < MS_MIN)
        begin
            fwd  = 1'b0;
            bwd  = 1'b0;
            slow = 1'b1;
        end
        else
        begin
            fwd  = a10 > 8 * m;
            bwd  = a10 < -8 * m;
            slow = a10 <= 3 * m;
        end
        last_angle = angle;
        if (loaded)
            ph = (angle < ANGLE_STANCE_LOW) ? PH_LOADING :
                 (angle < ANGLE_STANCE_HIGH) ? PH_MID_STANCE : PH_TERM_STANCE;
        else if (preswing)
            ph = PH_PRE_SWING;
        else if (unloading && fwd)
            ph = (angle < ANGLE_SWING_MID) ? PH_INITIAL_SWING : PH_MID_SWING;
        else if (unloading && (bwd || slow))
            ph = PH_TERM_SWING;
        else
            ph = PH_UNKNOWN;
        cmd.phase         = ph;
        cmd.knee_angle    = knee_deg[ph];
        cmd.target_steps  = STEPS_W'(knee_deg[ph] * 10);
        cmd.speed_sps     = speed_tab[ph];
        cmd.filtered_load = PRESSURE_W'(f >>> FRAC);
        return cmd;
    endfunction

    task automatic add_row(input int raw, input int angle, input int ms, input bit typed,
                           input phase_t ph, input int knee, input int steps,
                           input int speed, input int filt);
        sample_row_t r;
        r.raw                = PRESSURE_W'(raw);
        r.angle              = ANGLE_W'(angle);
        r.ms                 = MS_W'(ms);
        r.typed              = typed;
        r.cmd.emergency_stop = 1'b0;
        r.cmd.filtered_load  = PRESSURE_W'(filt);
        r.cmd.speed_sps      = SPEED_W'(speed);
        r.cmd.target_steps   = STEPS_W'(steps);
        r.cmd.knee_angle     = KNEE_W'(knee);
        r.cmd.phase          = ph;
        directed_rows.push_back(r);
    endtask

    task automatic send_sample(input logic [PRESSURE_W-1:0] raw,
                               input logic signed [ANGLE_W-1:0] angle,
                               input logic [MS_W-1:0] ms, input bit typed,
                               input gait_cmd_t typed_cmd);
        gait_cmd_t predicted;
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {{PAD_W{1'b0}}, ms, angle, raw};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predicted = classify_sample(raw, angle, ms);
        pending_cmds.push_back(typed ? typed_cmd : predicted);
        samples_sent++;
    endtask

    task automatic send_random_sample(input bit noise_only);
        logic [PRESSURE_W-1:0]     raw;
        logic signed [ANGLE_W-1:0] angle;
        logic [MS_W-1:0]           ms;
        int                        low_top;
        if (noise_only || $urandom_range(0, 99) < 25)
        begin
            raw   = PRESSURE_W'($urandom_range(0, raw_cap));
            angle = ANGLE_W'($urandom_range(0, 36000) - 18000);
            ms    = ($urandom_range(0, 3) == 0) ? MS_W'($urandom_range(0, 65535))
                                                : MS_W'($urandom_range(0, 40));
        end
        else
        begin
            // stance and swing stretches with a forward drifting shank
            if (walk_left == 0)
            begin
                walk_stance = !walk_stance;
                walk_left   = $urandom_range(2, 12);
            end
            walk_left--;
            low_top = (raw_cap < 250) ? raw_cap : 250;
            raw = walk_stance ? PRESSURE_W'($urandom_range(raw_cap / 2, raw_cap))
                              : PRESSURE_W'($urandom_range(0, low_top));
            walk_angle += int'($urandom_range(0, 900)) - 300;
            if (walk_angle > 6000)
                walk_angle = -int'($urandom_range(0, 3000));
            angle = ANGLE_W'(walk_angle);
            ms    = ($urandom_range(0, 9) == 0) ? MS_W'($urandom_range(0, 1))
                                                : MS_W'($urandom_range(2, 30));
        end
        send_sample(raw, angle, ms, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_setup(input int k);
        logic [PRESSURE_W-1:0] zero_v;
        logic [PRESSURE_W-1:0] span_v;
        logic [ALPHA_W-1:0]    alpha_v;
        logic [PRESSURE_W-1:0] loaded_v;
        logic [PRESSURE_W-1:0] pre_v;
        logic [PRESSURE_W-1:0] unload_v;
        logic [PRESSURE_W-1:0] stop_v;
        zero_v   = PRESSURE_W'($urandom_range(0, 400));
        span_v   = PRESSURE_W'($urandom_range(1, 1023));
        alpha_v  = ALPHA_W'($urandom_range(2000, 65536));
        loaded_v = PRESSURE_W'($urandom_range(100, 700));
        pre_v    = PRESSURE_W'($urandom_range(0, 300));
        unload_v = PRESSURE_W'($urandom_range(0, 400));
        stop_v   = ($urandom_range(0, 1) != 0) ? 10'd1023 : PRESSURE_W'($urandom_range(600, 1022));
        case (k)
            0:
            begin
                zero_v   = '0;
                span_v   = 10'd1023;
                alpha_v  = ALPHA_ONE;
                loaded_v = '0;
                pre_v    = '0;
                unload_v = 10'd1023;
                stop_v   = 10'd1023;
            end
            1:
            begin
                zero_v   = 10'd1023;
                span_v   = 10'd1;
                alpha_v  = '0;
                loaded_v = 10'd1023;
                pre_v    = 10'd1023;
                unload_v = '0;
            end
            2:
            begin
                span_v  = '0;
                alpha_v = '1;
            end
            3:
            begin
                loaded_v = PRESSURE_W'($urandom_range(0, 100));
                pre_v    = PRESSURE_W'($urandom_range(200, 600));
                unload_v = PRESSURE_W'($urandom_range(300, 900));
            end
            4:
            begin
                zero_v   = ZERO_RESET;
                span_v   = SPAN_RESET;
                alpha_v  = ALPHA_RESET;
                loaded_v = LOADED_RESET;
                pre_v    = PRESWING_RESET;
                unload_v = UNLOAD_RESET;
                stop_v   = STOP_RESET;
            end
            7:
                alpha_v = 17'd1;
            NUM_SETUPS:
                stop_v = '0;
            default: ;
        endcase
        write_reg(REG_PRESSURE_ZERO, CFG_DATA_W'(zero_v));
        write_reg(REG_PRESSURE_SPAN, CFG_DATA_W'(span_v));
        write_reg(REG_LOAD_ALPHA, alpha_v);
        write_reg(REG_LOADED_LEVEL, CFG_DATA_W'(loaded_v));
        write_reg(REG_PRESWING_LEVEL, CFG_DATA_W'(pre_v));
        write_reg(REG_UNLOAD_LEVEL, CFG_DATA_W'(unload_v));
        write_reg(REG_STOP_LEVEL, CFG_DATA_W'(stop_v));
        if (k == 6)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        raw_cap = int'(stop_v);
        setups_done++;
    endtask

    always @(negedge clk)
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);

    always @(posedge clk)
    begin
        gait_cmd_t got;
        gait_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata};
            if (pending_cmds.size() == 0)
            begin
                if (fault_count < 10)
                    $display("result transfer with nothing expected: %h", got);
                fault_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (got !== want)
                begin
                    if (fault_count < 10)
                        $display("result %0d: phase %0d/%0d knee %0d/%0d steps %0d/%0d speed %0d/%0d load %0d/%0d stop %0b/%0b (exp/act)",
                                 cmds_checked, want.phase, got.phase, want.knee_angle,
                                 got.knee_angle, want.target_steps, got.target_steps,
                                 want.speed_sps, got.speed_sps, want.filtered_load,
                                 got.filtered_load, want.emergency_stop, got.emergency_stop);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first row runs on the reset values, the rest with a full-weight filter
        add_row(0, 0, 0, 1, PH_TERM_SWING, 15, 150, 300, 0);
        add_row(1023, -18000, 100, 1, PH_LOADING, 10, 100, 250, 700);
        add_row(500, -401, 100, 1, PH_LOADING, 10, 100, 250, 380);
        add_row(500, -400, 100, 1, PH_MID_STANCE, 5, 50, 180, 380);
        add_row(366, 399, 1, 1, PH_MID_STANCE, 5, 50, 180, 246);
        add_row(365, 400, 100, 1, PH_PRE_SWING, 20, 200, 350, 245);
        add_row(820, 18000, 100, 1, PH_TERM_STANCE, 0, 0, 220, 700);
        add_row(191, 0, 100, 1, PH_PRE_SWING, 20, 200, 350, 71);
        add_row(190, 0, 10, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 0, 65535, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 200, 10, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 499, 2, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 500, 2, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 1000, 2, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 2000, 1, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 1000, 100, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 1008, 10, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 1017, 10, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 1020, 10, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, -32768, 65535, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(0, 32767, 65535, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(120, 0, 0, 0, PH_UNKNOWN, 0, 0, 0, 0);
        add_row(119, 0, 0, 0, PH_UNKNOWN, 0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            if (i == 1)
            begin
                settle();
                write_reg(REG_LOAD_ALPHA, '1);
                write_reg(REG_STOP_LEVEL, 17'd1023);
            end
            send_sample(directed_rows[i].raw, directed_rows[i].angle, directed_rows[i].ms,
                        directed_rows[i].typed, directed_rows[i].cmd);
        end
        settle();

        for (int k = 0; k < NUM_SETUPS; k++)
        begin
            program_setup(k);
            no_gaps = (k == 5);
            repeat (PHASE_ITEMS) send_random_sample(1'b0);
            settle();
        end
        no_gaps = 1'b0;

        // stop level at zero: quiet samples first, then the latch trips and holds
        program_setup(NUM_SETUPS);
        repeat (5) send_random_sample(1'b1);
        send_sample(PRESSURE_W'($urandom_range(1, 1023)), ANGLE_W'($urandom_range(0, 65535)),
                    MS_W'($urandom_range(0, 65535)), 1'b0, '0);
        raw_cap = 1023;
        repeat (40) send_random_sample(1'b1);
        settle();

        $display("%0d samples sent, %0d results checked over %0d register setups",
                 samples_sent, cmds_checked, setups_done + 1);
        $display("covered load and velocity boundaries, all phases, filter extremes and stop latch");
        if (fault_count == 0 && pending_cmds.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gpc_pkg.sv
rtl/gait_phase_classifier_core.sv
rtl/gpc_checker.sv
tb/sv/testbench.sv
